[src/ofre_pkg.sv]
// Shared types, codes and defaults of the overwriting ring FIFO engine.
`timescale 1ns / 1ps
package ofre_pkg;

  localparam int DepthDefault    = 256;
  localparam int MaxBurstDefault = 64;

  localparam int CAP_W  = 9;
  localparam int WORD_W = 16;
  localparam int LEN_W  = 7;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Command codes as they arrive on the request port.
  localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FETCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WOPEN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WWORD = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_ERR     = 2'd3;

  // Operations after classification; a get is a read burst of one word.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_READ,
    OP_FETCH,
    OP_WOPEN,
    OP_WWORD,
    OP_CLEAR,
    OP_BAD
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] word_in;
    logic [LEN_W-1:0]  burst_len;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic              word_valid;
    logic [STAT_W-1:0] status;
    logic [CAP_W-1:0]  fill_count;
    logic              is_full;
    logic              is_empty;
    logic              last;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

[src/ofre_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ofre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ofre_front.sv]
// Front end: accepts items, classifies the command and queues it for the back end.
`timescale 1ns / 1ps
module ofre_front #(
  parameter int MAX_BURST = ofre_pkg::MaxBurstDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ofre_pkg::req_t   req_i,
  output logic             q_valid_o,
  output ofre_pkg::cmd_t   q_item_o,
  input  logic             q_pop_i
);

  localparam logic [ofre_pkg::LEN_W-1:0] LenMax = ofre_pkg::LEN_W'(MAX_BURST);

  ofre_pkg::cmd_t ent_q [2];
  ofre_pkg::cmd_t cls;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;
  logic [ofre_pkg::LEN_W-1:0] len_sat;

  assign len_sat = (req_i.burst_len > LenMax) ? LenMax : req_i.burst_len;

  always_comb begin
    cls.word = req_i.word_in;
    cls.len  = len_sat;
    case (req_i.cmd)
      ofre_pkg::CMD_PUT:   cls.op = ofre_pkg::OP_PUT;
      ofre_pkg::CMD_GET: begin
        cls.op  = ofre_pkg::OP_READ;
        cls.len = ofre_pkg::LEN_W'(1);
      end
      ofre_pkg::CMD_READ:  cls.op = ofre_pkg::OP_READ;
      ofre_pkg::CMD_FETCH: cls.op = ofre_pkg::OP_FETCH;
      ofre_pkg::CMD_WOPEN: cls.op = ofre_pkg::OP_WOPEN;
      ofre_pkg::CMD_WWORD: cls.op = ofre_pkg::OP_WWORD;
      ofre_pkg::CMD_CLEAR: cls.op = ofre_pkg::OP_CLEAR;
      default:             cls.op = ofre_pkg::OP_BAD;
    endcase
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_item_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

[src/ofre_back.sv]
// Back end: carries out queued commands on the ring state and produces results.
`timescale 1ns / 1ps
module ofre_back #(
  parameter int DEPTH = ofre_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ofre_pkg::cmd_t              q_item_i,
  output logic                        q_pop_o,
  input  logic                        cfg_we_i,
  input  logic [ofre_pkg::CAP_W-1:0]  cfg_wdata_i,
  output logic                        ram_we_o,
  output logic [$clog2(DEPTH)-1:0]    ram_waddr_o,
  output logic [ofre_pkg::WORD_W-1:0] ram_wdata_o,
  output logic [$clog2(DEPTH)-1:0]    ram_raddr_o,
  input  logic [ofre_pkg::WORD_W-1:0] ram_rdata_i,
  output ofre_pkg::rsp_t              rsp_o,
  output logic                        rsp_strobe_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int WW = ((IW > ofre_pkg::CAP_W) ? IW : ofre_pkg::CAP_W) + 1;
  localparam int CW = ofre_pkg::CAP_W;
  localparam int LW = ofre_pkg::LEN_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  function automatic logic [IW-1:0] wrap_nx(input logic [IW-1:0] idx,
                                            input logic [CW-1:0] cap);
    logic [WW-1:0] s;
    s = WW'(idx) + WW'(1);
    return (s >= WW'(cap)) ? '0 : s[IW-1:0];
  endfunction

  function automatic logic [CW-1:0] held_of(input logic [IW-1:0] wr,
                                            input logic [IW-1:0] rd,
                                            input logic          full,
                                            input logic [CW-1:0] cap);
    logic [WW-1:0] h;
    if (full) h = WW'(cap);
    else if (wr >= rd) h = WW'(wr) - WW'(rd);
    else h = WW'(cap) + WW'(wr) - WW'(rd);
    return h[CW-1:0];
  endfunction

  logic          state_q, state_d;
  logic [IW-1:0] wr_q, wr_d, rd_q, rd_d, ptr_q, ptr_d;
  logic          full_q, full_d, bacc_q, bacc_d, peek_q, peek_d;
  logic [LW-1:0] brem_q, brem_d, cnt_q, cnt_d;
  logic [CW-1:0] cap_q, eff_cap, held_now;

  logic                        strobe_q, strobe_d;
  logic                        wv_q, wv_d, last_q, last_d, isf_q, ise_q;
  logic [ofre_pkg::STAT_W-1:0] st_q, st_d;
  logic [CW-1:0]               fill_q;
  logic                        do_put, empty_now;
  logic [LW-1:0]               brem_dec;

  always_comb begin
    if (cap_q == '0) eff_cap = CW'(1);
    else if (32'(cap_q) > 32'(DEPTH)) eff_cap = CW'(DEPTH);
    else eff_cap = cap_q;
  end

  assign held_now  = held_of(wr_q, rd_q, full_q, eff_cap);
  assign empty_now = !full_q && (wr_q == rd_q);
  assign brem_dec  = brem_q - LW'(1);

  always_comb begin
    state_d  = state_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    full_d   = full_q;
    bacc_d   = bacc_q;
    brem_d   = brem_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    peek_d   = peek_q;
    q_pop_o  = 1'b0;
    do_put   = 1'b0;
    strobe_d = 1'b0;
    wv_d     = 1'b0;
    last_d   = 1'b1;
    st_d     = ofre_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            ofre_pkg::OP_PUT: begin
              do_put   = 1'b1;
              strobe_d = 1'b1;
            end
            ofre_pkg::OP_READ: begin
              if (q_item_i.len == '0) begin
                strobe_d = 1'b1;
              end else begin
                state_d = S_RUN;
                cnt_d   = q_item_i.len;
                peek_d  = 1'b0;
              end
            end
            ofre_pkg::OP_FETCH: begin
              if (CW'(q_item_i.len) > held_now) begin
                strobe_d = 1'b1;
                st_d     = ofre_pkg::ST_ERR;
              end else if (q_item_i.len == '0) begin
                strobe_d = 1'b1;
              end else begin
                state_d = S_RUN;
                cnt_d   = q_item_i.len;
                peek_d  = 1'b1;
                ptr_d   = rd_q;
              end
            end
            ofre_pkg::OP_WOPEN: begin
              brem_d   = q_item_i.len;
              strobe_d = 1'b1;
              if (full_q) st_d = ofre_pkg::ST_FULL;
              else if ((eff_cap - held_now) < CW'(q_item_i.len)) st_d = ofre_pkg::ST_NOSPACE;
              else st_d = ofre_pkg::ST_OK;
              bacc_d = (st_d == ofre_pkg::ST_OK);
            end
            ofre_pkg::OP_WWORD: begin
              strobe_d = 1'b1;
              if (brem_q == '0) begin
                bacc_d = 1'b0;
                st_d   = ofre_pkg::ST_ERR;
              end else begin
                brem_d = brem_dec;
                if (brem_dec == '0) bacc_d = 1'b0;
                if (bacc_q) do_put = 1'b1;
                else st_d = ofre_pkg::ST_ERR;
              end
            end
            ofre_pkg::OP_CLEAR: begin
              wr_d     = '0;
              rd_d     = '0;
              full_d   = 1'b0;
              bacc_d   = 1'b0;
              brem_d   = '0;
              strobe_d = 1'b1;
            end
            default: begin
              strobe_d = 1'b1;
              st_d     = ofre_pkg::ST_ERR;
            end
          endcase
        end
      end
      S_RUN: begin
        strobe_d = 1'b1;
        if (peek_q) begin
          wv_d   = 1'b1;
          last_d = (cnt_q == LW'(1));
          ptr_d  = wrap_nx(ptr_q, eff_cap);
          cnt_d  = cnt_q - LW'(1);
          if (cnt_q == LW'(1)) state_d = S_IDLE;
        end else if (empty_now) begin
          // The FIFO ran dry before the burst finished.
          st_d    = ofre_pkg::ST_ERR;
          state_d = S_IDLE;
        end else begin
          wv_d   = 1'b1;
          last_d = (cnt_q == LW'(1));
          rd_d   = wrap_nx(rd_q, eff_cap);
          full_d = 1'b0;
          cnt_d  = cnt_q - LW'(1);
          if (cnt_q == LW'(1)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A put on a full FIFO drops the oldest word by moving the read index along.
    if (do_put) begin
      if (full_q) rd_d = wrap_nx(rd_q, eff_cap);
      wr_d   = wrap_nx(wr_q, eff_cap);
      full_d = (wr_d == rd_d);
    end
  end

  assign ram_we_o    = do_put;
  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = q_item_i.word;
  assign ram_raddr_o = peek_q ? ptr_q : rd_q;

  always_ff @(posedge clk_i) begin
    wv_q   <= wv_d;
    last_q <= last_d;
    st_q   <= st_d;
    fill_q <= held_of(wr_d, rd_d, full_d, eff_cap);
    isf_q  <= full_d;
    ise_q  <= !full_d && (wr_d == rd_d);
    ptr_q  <= ptr_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_q     <= '0;
      rd_q     <= '0;
      full_q   <= 1'b0;
      bacc_q   <= 1'b0;
      brem_q   <= '0;
      peek_q   <= 1'b0;
      cap_q    <= ofre_pkg::CAP_RESET;
      strobe_q <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q    <= cfg_wdata_i;
      state_q  <= S_IDLE;
      wr_q     <= '0;
      rd_q     <= '0;
      full_q   <= 1'b0;
      bacc_q   <= 1'b0;
      brem_q   <= '0;
      peek_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      full_q   <= full_d;
      bacc_q   <= bacc_d;
      brem_q   <= brem_d;
      peek_q   <= peek_d;
      strobe_q <= strobe_d;
    end
  end

  // The read data arrives together with the registered result fields.
  assign rsp_o.word_out   = wv_q ? ram_rdata_i : '0;
  assign rsp_o.word_valid = wv_q;
  assign rsp_o.status     = st_q;
  assign rsp_o.fill_count = fill_q;
  assign rsp_o.is_full    = isf_q;
  assign rsp_o.is_empty   = ise_q;
  assign rsp_o.last       = last_q;
  assign rsp_strobe_o     = strobe_q;

endmodule

[src/overwriting_ring_fifo_engine.sv]
// Top level of the overwriting ring FIFO engine: front end, back end and word store.
//
// An item is a command (put, get, read burst, fetch burst, write open, write word,
// clear) on req_i, taken at a clock edge where start is high and busy is low.
// Results leave on rsp_o, each valid for exactly one cycle while rsp_strobe_o is
// high; the receiver cannot hold them off. The last result of an item has last set.
// The front end decodes commands into a two-entry queue, so busy only rises when
// that queue is full. The back end works off one queued command at a time.
// An item passes through the front end's queue to the back end, whose results are
// registered; a get, a read burst of nonzero length and a fetch burst that returns
// words also go through the S_RUN state. The other commands sustain one item per cycle
// while no burst holds the back end; a get or such a burst keeps the back end in S_RUN
// until its last result, each word read through the store's single read port.
// Writing the capacity register on cfg_we_i empties the FIFO and cancels any
// pending write burst; write it only while the block is idle.
// Reset empties the FIFO and sets the capacity to 256; no clearing pass is needed.
`timescale 1ns / 1ps
module overwriting_ring_fifo_engine #(
  parameter int DEPTH     = ofre_pkg::DepthDefault,
  parameter int MAX_BURST = ofre_pkg::MaxBurstDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ofre_pkg::req_t             req_i,
  output ofre_pkg::rsp_t             rsp_o,
  output logic                       rsp_strobe_o,
  input  logic                       cfg_we_i,
  input  logic [ofre_pkg::CAP_W-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(DEPTH);

  logic                        q_valid, q_pop;
  ofre_pkg::cmd_t              q_item;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [ofre_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  ofre_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .q_valid_o(q_valid),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  ofre_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_o       (rsp_o),
    .rsp_strobe_o(rsp_strobe_o)
  );

  ofre_ram #(
    .WIDTH(ofre_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
